@@ sv/random_cell_picker_without_repeat_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the random cell picker.
// Shared property forms with a common clock and reset.
// ---------------------------------------------------------------------------
`ifndef RANDOM_CELL_PICKER_WITHOUT_REPEAT_MACROS_SVH
`define RANDOM_CELL_PICKER_WITHOUT_REPEAT_MACROS_SVH

// Same-cycle implication.
`define RCP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/rcp_pkg.sv @@
// ---------------------------------------------------------------------------
// rcp_pkg
// Types, constants and controller interface of the random cell picker.
// ---------------------------------------------------------------------------
package rcp_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int KEY_W = 20;
	localparam int CNT_W = 21;
	localparam int DIV_W = 32;
	localparam logic [CNT_W-1:0] MAX_CELLS = 21'h100000;
	localparam logic [31:0] HASH_MUL = 32'd2654435761;
	localparam logic [IDX_W-1:0] HASH_LO = HASH_MUL[IDX_W-1:0];

	localparam logic FUNC_FLIP = 1'b0;
	localparam logic FUNC_RESET = 1'b1;

	localparam logic [7:0] CFG_ROW = 8'd0;
	localparam logic [7:0] CFG_COL = 8'd1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// One table entry: valid bit, key and image.
	typedef struct packed {
		logic used;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] val;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_start;
		logic clr_step;
		logic accept;
		logic load_total;
		logic load_rem;
		logic div_start;
		logic div_sel;
		logic hash_load;
		logic hash_sel;
		logic load_r;
		logic probe_next;
		logic load_x;
		logic load_lval;
		logic write_slot;
		logic load_out;
		status_t out_st;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic empty;
		logic div_done;
		logic hit;
		logic exhaust;
	} sts_t;

endpackage

@@ sv/rcp_div.sv @@
// ---------------------------------------------------------------------------
// rcp_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rcp_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [rcp_pkg::DIV_W-1:0] dividend,
	input logic [rcp_pkg::CNT_W-1:0] divisor,
	output logic done,
	output logic [rcp_pkg::DIV_W-1:0] quot,
	output logic [rcp_pkg::CNT_W-1:0] rem
);

	logic busy_q;
	logic done_q;
	logic [$clog2(rcp_pkg::DIV_W)-1:0] cnt_q;
	logic [rcp_pkg::DIV_W-1:0] quo_q;
	logic [rcp_pkg::CNT_W-1:0] rem_q;
	logic [rcp_pkg::CNT_W-1:0] d_q;
	logic [rcp_pkg::CNT_W:0] sh;
	logic ge;

	// Shift in the next dividend bit and try the subtraction.
	assign sh = {rem_q, quo_q[rcp_pkg::DIV_W-1]};
	assign ge = sh >= {1'b0, d_q};

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rcp_pkg::CNT_W'(sh - {1'b0, d_q}) : sh[rcp_pkg::CNT_W-1:0];
			quo_q <= {quo_q[rcp_pkg::DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem = rem_q;

endmodule

@@ sv/rcp_datapath.sv @@
// ---------------------------------------------------------------------------
// rcp_datapath
// Configuration, counters, remap table memory, hashing and division.
// ---------------------------------------------------------------------------
module rcp_datapath (
	input logic clk,
	input logic arst_n,
	input rcp_pkg::cmd_t cmd,
	output rcp_pkg::sts_t sts,
	input logic cfg_we,
	input logic [7:0] cfg_index,
	input logic [10:0] cfg_data,
	input logic [31:0] random_word,
	output logic [9:0] row,
	output logic [9:0] col,
	output logic [1:0] status
);

	localparam int IW = rcp_pkg::IDX_W;
	localparam int KW = rcp_pkg::KEY_W;
	localparam int CW = rcp_pkg::CNT_W;

	logic [10:0] row_cnt_q;
	logic [10:0] col_cnt_q;
	logic [CW-1:0] flips_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] remain_q;
	logic [31:0] word_q;
	logic [KW-1:0] r_q;
	logic [KW-1:0] key_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] cnt_q;
	logic [IW-1:0] slot_q;
	logic [IW-1:0] clr_q;
	logic [KW-1:0] x_q;
	logic [KW-1:0] lval_q;
	logic [9:0] row_q;
	logic [9:0] col_q;
	rcp_pkg::status_t st_q;
	rcp_pkg::entry_t mem [rcp_pkg::TABLE_DEPTH];
	rcp_pkg::entry_t rd_q;

	logic [21:0] prod;
	logic [KW-1:0] hkey;
	logic [2*IW-1:0] hprod;
	logic match;
	logic div_done;
	logic [rcp_pkg::DIV_W-1:0] div_quot;
	logic [CW-1:0] div_rem;
	logic [rcp_pkg::DIV_W-1:0] div_a;
	logic [CW-1:0] div_b;

	// Grid size and hash of the selected key.
	assign prod = row_cnt_q * col_cnt_q;
	assign hkey = cmd.hash_sel ? KW'(remain_q - 1'b1) : r_q;
	assign hprod = (2*IW)'(hkey[IW-1:0]) * (2*IW)'(rcp_pkg::HASH_LO);
	assign match = rd_q.used && (rd_q.key == key_q);

	// Shared divider operands: random word by remaining count, or cell by columns.
	assign div_a = cmd.div_sel ? rcp_pkg::DIV_W'(x_q) : word_q;
	assign div_b = cmd.div_sel ? CW'(col_cnt_q) : remain_q;

	rcp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend(div_a),
		.divisor(div_b),
		.done(div_done),
		.quot(div_quot),
		.rem(div_rem)
	);

	// Configuration registers and flip counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= 11'd1;
			col_cnt_q <= 11'd1;
			flips_q <= '0;
		end else begin
			if (cfg_we && cfg_index == rcp_pkg::CFG_ROW) begin
				row_cnt_q <= cfg_data;
			end
			if (cfg_we && cfg_index == rcp_pkg::CFG_COL) begin
				col_cnt_q <= cfg_data;
			end
			if (cmd.clr_start) begin
				flips_q <= '0;
			end else if (cmd.write_slot) begin
				flips_q <= flips_q + 1'b1;
			end
		end
	end

	// Clearing sweep address; it starts at zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_start) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Working registers of one flip.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			word_q <= random_word;
		end
		if (cmd.load_total) begin
			total_q <= (prod > 22'(rcp_pkg::MAX_CELLS)) ? rcp_pkg::MAX_CELLS : prod[CW-1:0];
		end
		if (cmd.load_rem) begin
			remain_q <= total_q - flips_q;
		end
		if (cmd.load_r) begin
			r_q <= div_rem[KW-1:0];
		end
		if (cmd.hash_load) begin
			key_q <= hkey;
			idx_q <= hprod[IW-1:0];
			cnt_q <= '0;
		end else if (cmd.probe_next) begin
			idx_q <= idx_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.load_x) begin
			slot_q <= idx_q;
			x_q <= match ? rd_q.val : r_q;
		end
		if (cmd.load_lval) begin
			lval_q <= match ? rd_q.val : key_q;
		end
		if (cmd.load_out) begin
			st_q <= cmd.out_st;
			row_q <= (cmd.out_st == rcp_pkg::ST_OK) ? div_quot[9:0] : 10'd0;
			col_q <= (cmd.out_st == rcp_pkg::ST_OK) ? div_rem[9:0] : 10'd0;
		end
	end

	// Remap table: clearing sweep, slot write and probe read.
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			mem[clr_q] <= '{used: 1'b0, key: '0, val: '0};
		end else if (cmd.write_slot) begin
			mem[slot_q] <= '{used: 1'b1, key: r_q, val: lval_q};
		end
		rd_q <= mem[idx_q];
	end

	assign sts.clr_last = clr_q == '1;
	assign sts.empty = flips_q >= total_q;
	assign sts.div_done = div_done;
	assign sts.hit = !rd_q.used || (rd_q.key == key_q);
	assign sts.exhaust = cnt_q == '1;

	assign row = row_q;
	assign col = col_q;
	assign status = st_q;

endmodule

@@ sv/rcp_ctrl.sv @@
// ---------------------------------------------------------------------------
// rcp_ctrl
// Sequencer of the flip and clear operations and the output handshake.
// ---------------------------------------------------------------------------
module rcp_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic func,
	output logic out_valid,
	input logic out_ready,
	input rcp_pkg::sts_t sts,
	output rcp_pkg::cmd_t cmd
);

	typedef enum logic [15:0] {
		S_CLEAR = 16'h0001,
		S_IDLE = 16'h0002,
		S_TOTAL = 16'h0004,
		S_CHECK = 16'h0008,
		S_DIV1S = 16'h0010,
		S_DIV1W = 16'h0020,
		S_HASH1 = 16'h0040,
		S_P1RD = 16'h0080,
		S_P1CK = 16'h0100,
		S_HASH2 = 16'h0200,
		S_P2RD = 16'h0400,
		S_P2CK = 16'h0800,
		S_WRITE = 16'h1000,
		S_DIV2S = 16'h2000,
		S_DIV2W = 16'h4000,
		S_FINISH = 16'h8000
	} state_t;

	state_t state_q, state_d;
	rcp_pkg::status_t st_q, st_d;
	logic out_valid_q;
	logic accept;

	assign in_ready = state_q == S_IDLE;
	assign accept = in_valid && in_ready;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		st_d = st_q;
		cmd = '0;
		cmd.out_st = st_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.accept = 1'b1;
					if (func == rcp_pkg::FUNC_RESET) begin
						cmd.clr_start = 1'b1;
						state_d = S_CLEAR;
					end else begin
						state_d = S_TOTAL;
					end
				end
			end
			S_TOTAL: begin
				cmd.load_total = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.empty) begin
					st_d = rcp_pkg::ST_EMPTY;
					state_d = S_FINISH;
				end else begin
					cmd.load_rem = 1'b1;
					state_d = S_DIV1S;
				end
			end
			S_DIV1S: begin
				cmd.div_start = 1'b1;
				state_d = S_DIV1W;
			end
			S_DIV1W: begin
				if (sts.div_done) begin
					cmd.load_r = 1'b1;
					state_d = S_HASH1;
				end
			end
			S_HASH1: begin
				cmd.hash_load = 1'b1;
				state_d = S_P1RD;
			end
			S_P1RD: begin
				state_d = S_P1CK;
			end
			S_P1CK: begin
				if (sts.hit) begin
					cmd.load_x = 1'b1;
					state_d = S_HASH2;
				end else if (sts.exhaust) begin
					st_d = rcp_pkg::ST_FULL;
					state_d = S_FINISH;
				end else begin
					cmd.probe_next = 1'b1;
					state_d = S_P1RD;
				end
			end
			S_HASH2: begin
				cmd.hash_load = 1'b1;
				cmd.hash_sel = 1'b1;
				state_d = S_P2RD;
			end
			S_P2RD: begin
				state_d = S_P2CK;
			end
			S_P2CK: begin
				if (sts.hit || sts.exhaust) begin
					cmd.load_lval = 1'b1;
					state_d = S_WRITE;
				end else begin
					cmd.probe_next = 1'b1;
					state_d = S_P2RD;
				end
			end
			S_WRITE: begin
				cmd.write_slot = 1'b1;
				state_d = S_DIV2S;
			end
			S_DIV2S: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = 1'b1;
				state_d = S_DIV2W;
			end
			S_DIV2W: begin
				cmd.div_sel = 1'b1;
				if (sts.div_done) begin
					st_d = rcp_pkg::ST_OK;
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// The remainder of the cell division stays in the divider until the result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			st_q <= rcp_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q <= st_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/random_cell_picker_without_repeat.sv @@
// ---------------------------------------------------------------------------
// random_cell_picker_without_repeat
// Picks free grid cells at random without repetition.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word: func and random_word.
// A flip word yields one result word (row, col, status) on the output
// channel; a reset word yields none and frees every cell again.
// Configuration words (cfg_valid/cfg_ready, always ready) set row_count
// (index 0) and col_count (index 1); the user must write them only while
// the block is idle; the block itself does not enforce it.
// A flip makes two passes of the shared one-bit-per-cycle divider and two
// probes of the remap memory, a read state and a check state per slot
// visited. A flip on an exhausted grid skips both and reports empty.
// A reset word clears one table entry per cycle; after arst_n the same
// clearing pass runs before the first word is taken, and registers return
// to one row and one column.
// A finished result waits in an output register; a new word is accepted
// while it waits, and the next result is held until the receiver takes it.
// ---------------------------------------------------------------------------
`include "random_cell_picker_without_repeat_macros.svh"

module random_cell_picker_without_repeat (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic func,
	input logic [31:0] random_word,
	output logic out_valid,
	input logic out_ready,
	output logic [9:0] row,
	output logic [9:0] col,
	output logic [1:0] status,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_index,
	input logic [10:0] cfg_data
);

	rcp_pkg::cmd_t cmd;
	rcp_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	// Controller.
	rcp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts(sts),
		.cmd(cmd)
	);

	// Datapath.
	rcp_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.random_word(random_word),
		.row(row),
		.col(col),
		.status(status)
	);

	// Any accepted word keeps the block busy for at least the next cycle.
	`RCP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted word did not make the block busy")
	// A result is only loaded with a known status code.
	`RCP_ASSERT_SAME(a_status_code, out_valid, status <= rcp_pkg::ST_FULL, "result carries an undefined status")
	// A failed flip never reports a cell.
	`RCP_ASSERT_SAME(a_fail_zero, out_valid && status != rcp_pkg::ST_OK, row == 10'd0 && col == 10'd0, "failed flip reports a cell")
	// The table is never swept and written in the same cycle.
	`RCP_ASSERT_SAME(a_no_clash, cmd.clr_step, !cmd.write_slot && !cmd.load_out, "clearing overlaps a flip")

endmodule

@@ sim/random_cell_picker_without_repeat_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Random cell picker testbench
// Drives flip and reset words through the valid/ready channels under several
// grid sizes, predicts every result word with a shadow remap table and checks
// row, column and status in order.
// ---------------------------------------------------------------------------
module random_cell_picker_without_repeat_test;

	// Expected result word.
	typedef struct {
		bit [9:0] row;
		bit [9:0] col;
		rcp_pkg::status_t st;
	} pick_t;

	// Shadow of the picker: grid size, remap table and pending results.
	class pick_scoreboard;
		int unsigned rows = 1;
		int unsigned cols = 1;
		bit used[rcp_pkg::TABLE_DEPTH];
		bit [rcp_pkg::KEY_W-1:0] keys[rcp_pkg::TABLE_DEPTH];
		bit [rcp_pkg::KEY_W-1:0] vals[rcp_pkg::TABLE_DEPTH];
		int unsigned used_cnt;
		int unsigned flips;
		pick_t picks[$];
		int errors;

		function void clear_grid();
			foreach (used[i]) used[i] = 0;
			used_cnt = 0;
			flips = 0;
		endfunction

		function void set_reg(bit [7:0] idx, bit [10:0] data);
			if (idx == rcp_pkg::CFG_ROW) rows = data;
			else if (idx == rcp_pkg::CFG_COL) cols = data;
		endfunction

		function longint unsigned total_cells();
			longint unsigned t;
			t = longint'(rows) * longint'(cols);
			return (t > rcp_pkg::MAX_CELLS) ? rcp_pkg::MAX_CELLS : t;
		endfunction

		function int unsigned remaining();
			longint unsigned t;
			t = total_cells();
			return (flips >= t) ? 0 : int'(t - flips);
		endfunction

		// Slot holding the key, else first free slot on its path, else depth.
		function int unsigned find_slot(bit [rcp_pkg::KEY_W-1:0] key);
			bit [31:0] h;
			int unsigned s;
			h = {12'b0, key} * rcp_pkg::HASH_MUL;
			s = h % rcp_pkg::TABLE_DEPTH;
			for (int n = 0; n < rcp_pkg::TABLE_DEPTH; n++) begin
				if (!used[s] || keys[s] == key) return s;
				s = (s + 1) % rcp_pkg::TABLE_DEPTH;
			end
			return rcp_pkg::TABLE_DEPTH;
		endfunction

		function bit [rcp_pkg::KEY_W-1:0] image_of(bit [rcp_pkg::KEY_W-1:0] key);
			int unsigned s;
			s = find_slot(key);
			if (s < rcp_pkg::TABLE_DEPTH && used[s]) return vals[s];
			return key;
		endfunction

		// Called for every accepted input word.
		function void note_word(bit f, bit [31:0] w);
			pick_t p;
			int unsigned rem, r, s;
			bit [rcp_pkg::KEY_W-1:0] x, lv;
			if (f == rcp_pkg::FUNC_RESET) begin
				clear_grid();
				return;
			end
			p.row = 0;
			p.col = 0;
			rem = remaining();
			if (rem == 0) begin
				p.st = rcp_pkg::ST_EMPTY;
			end else begin
				r = w % rem;
				s = find_slot(r);
				if (s >= rcp_pkg::TABLE_DEPTH) begin
					p.st = rcp_pkg::ST_FULL;
				end else begin
					x = image_of(r);
					lv = image_of(rem - 1);
					if (!used[s]) begin
						used[s] = 1;
						keys[s] = r;
						used_cnt++;
					end
					vals[s] = lv;
					flips++;
					p.row = (x / cols) & 10'h3FF;
					p.col = (x % cols) & 10'h3FF;
					p.st = rcp_pkg::ST_OK;
				end
			end
			picks.push_back(p);
		endfunction

		// Called for every accepted result word.
		function void check_word(bit [9:0] row, bit [9:0] col, bit [1:0] st);
			pick_t p;
			if (picks.size() == 0) begin
				$display("%0t: unexpected result row %0d col %0d status %0d",
					$time, row, col, st);
				errors++;
				return;
			end
			p = picks.pop_front();
			if (row !== p.row) begin
				$display("%0t: row expected %0d actual %0d", $time, p.row, row);
				errors++;
			end
			if (col !== p.col) begin
				$display("%0t: col expected %0d actual %0d", $time, p.col, col);
				errors++;
			end
			if (st !== p.st) begin
				$display("%0t: status expected %0d actual %0d", $time, p.st, st);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic func;
	logic [31:0] random_word;
	logic out_valid;
	logic out_ready;
	logic [9:0] row;
	logic [9:0] col;
	logic [1:0] status;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] cfg_index;
	logic [10:0] cfg_data;

	pick_scoreboard sb = new();
	int tx_idle;
	int rx_idle;

	random_cell_picker_without_repeat dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.random_word(random_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.row(row),
		.col(col),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls at the current idle rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle);
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_word(row, col, status);
	end

	// Sends one input word and records it once accepted.
	task automatic send_word(bit f, bit [31:0] w);
		in_valid <= 1;
		func <= f;
		random_word <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_word(f, w);
	endtask

	// Random sender gap.
	task automatic sender_gap();
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
	endtask

	// Waits for all pending results, then for a possible reset pass.
	task automatic drain(int settle);
		in_valid <= 0;
		@(posedge clk);
		while (sb.picks.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Writes one register; the caller lowers cfg_valid afterwards.
	task automatic write_reg(bit [7:0] idx, bit [10:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	task automatic set_grid(bit [10:0] r, bit [10:0] c);
		drain(4200);
		write_reg(rcp_pkg::CFG_ROW, r);
		write_reg(rcp_pkg::CFG_COL, c);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// Random word: mostly uniform, sometimes an edge of the live range.
	function automatic bit [31:0] pick_word();
		int unsigned rem;
		rem = sb.remaining();
		case ($urandom_range(9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return (rem == 0) ? 32'h0 : rem - 1;
			3: return rem;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		bit [10:0] grid_r[7];
		bit [10:0] grid_c[7];
		int unsigned n;
		int timer;
		in_valid <= 0;
		func <= rcp_pkg::FUNC_FLIP;
		random_word <= 0;
		cfg_valid <= 0;
		cfg_index <= 0;
		cfg_data <= 0;
		out_ready <= 0;
		tx_idle = 0;
		rx_idle = 0;
		arst_n <= 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		sb.clear_grid();

		// Directed: one-cell grid, then a 3 x 5 grid drawn to exhaustion.
		send_word(rcp_pkg::FUNC_FLIP, 32'hFFFF_FFFF);
		send_word(rcp_pkg::FUNC_FLIP, 32'h0);
		set_grid(3, 5);
		send_word(rcp_pkg::FUNC_FLIP, 32'h0);
		send_word(rcp_pkg::FUNC_FLIP, 32'hFFFF_FFFF);
		send_word(rcp_pkg::FUNC_FLIP, sb.remaining() - 1);
		send_word(rcp_pkg::FUNC_FLIP, 32'h8000_0000);
		send_word(rcp_pkg::FUNC_FLIP, 32'h5555_5555);
		send_word(rcp_pkg::FUNC_FLIP, 32'hAAAA_AAAA);
		send_word(rcp_pkg::FUNC_RESET, 32'hFFFF_FFFF);
		while (sb.remaining() != 0) send_word(rcp_pkg::FUNC_FLIP, $urandom());
		send_word(rcp_pkg::FUNC_FLIP, 32'h1234_5678);
		// Lowered registers leave the grid exhausted; ignored indexes too.
		drain(4200);
		write_reg(rcp_pkg::CFG_ROW, 1);
		write_reg(8'd2, 11'h7FF);
		write_reg(8'hFF, 11'h000);
		cfg_valid <= 0;
		@(posedge clk);
		send_word(rcp_pkg::FUNC_FLIP, 32'h0);

		// Random phases over several grid sizes and idle patterns.
		grid_r = '{2, 0, 2047, 1, 1024, 37, 1};
		grid_c = '{3, 7, 2047, 1, 1024, 29, 2047};
		n = 0;
		for (int ph = 0; ph < 7; ph++) begin
			set_grid(grid_r[ph], grid_c[ph]);
			send_word(rcp_pkg::FUNC_RESET, $urandom());
			for (int i = 0; i < 257; i++) begin
				if (n < 600) begin
					tx_idle = 16;
					rx_idle = 61;
				end else if (n < 1200) begin
					tx_idle = 61;
					rx_idle = 16;
				end else begin
					tx_idle = 0;
					rx_idle = 0;
				end
				if (n == 900) drain(0);
				sender_gap();
				if ($urandom_range(99) < 2) send_word(rcp_pkg::FUNC_RESET, $urandom());
				else send_word(rcp_pkg::FUNC_FLIP, pick_word());
				n++;
			end
		end

		// Let the last results out, then report.
		in_valid <= 0;
		timer = 0;
		while (sb.picks.size() != 0 && timer < 200000) begin
			@(posedge clk);
			timer++;
		end
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.picks.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Overall time limit.
	initial begin
		#60ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/rcp_pkg.sv
sv/rcp_div.sv
sv/rcp_datapath.sv
sv/rcp_ctrl.sv
sv/random_cell_picker_without_repeat.sv
sim/random_cell_picker_without_repeat_test.sv
